// ----- hw/rtl/euler_point_rotation_unit_macros.svh -----
// ----------------------------------------------------------------------------
// euler point rotation assertion macros
// assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef EULER_POINT_ROTATION_UNIT_MACROS_SVH
`define EULER_POINT_ROTATION_UNIT_MACROS_SVH
`ifndef SYNTH
`define EPR_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: label");
`define EPR_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: label");
`else
`define EPR_ASSERT_CLK(label, clk, rst_n, prop)
`define EPR_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- hw/rtl/epr_pkg.sv -----
// ----------------------------------------------------------------------------
// epr_pkg
// shared types, constants and the arctangent table for the rotation unit
// ----------------------------------------------------------------------------
package epr_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS    = 30;
  localparam int PH_W            = 34;
  localparam int CV_W            = 33;
  localparam int ME_W            = 31;
  localparam int QUEUE_DEPTH     = 4;
  localparam logic signed [CV_W-1:0] CORDIC_GAIN = CV_W'(652032874);

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] point_x;
    logic signed [COORD_WIDTH_DEF-1:0] point_y;
    logic signed [COORD_WIDTH_DEF-1:0] point_z;
    logic signed [ANGLE_WIDTH_DEF-1:0] angle_about_x;
    logic signed [ANGLE_WIDTH_DEF-1:0] angle_about_y;
    logic signed [ANGLE_WIDTH_DEF-1:0] angle_about_z;
  } epr_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] rotated_x;
    logic signed [COORD_WIDTH_DEF-1:0] rotated_y;
    logic signed [COORD_WIDTH_DEF-1:0] rotated_z;
  } epr_out_t;

  typedef struct packed {
    logic ovf;
    logic full;
  } epr_q_stat_t;

  function automatic logic signed [PH_W-1:0] atan_lut(input int i);
    logic [29:0] v;
    unique case (i)
      0: v = 30'h20000000;  1: v = 30'h12E4051E;  2: v = 30'h09FB385B;
      3: v = 30'h051111D4;  4: v = 30'h028B0D43;  5: v = 30'h0145D7E1;
      6: v = 30'h00A2F61E;  7: v = 30'h00517C55;  8: v = 30'h0028BE53;
      9: v = 30'h00145F2F; 10: v = 30'h000A2F98; 11: v = 30'h000517CC;
      12: v = 30'h00028BE6; 13: v = 30'h000145F3; 14: v = 30'h0000A2FA;
      15: v = 30'h0000517D; 16: v = 30'h000028BE; 17: v = 30'h0000145F;
      18: v = 30'h00000A30; 19: v = 30'h00000518; 20: v = 30'h0000028C;
      21: v = 30'h00000146; 22: v = 30'h000000A3; 23: v = 30'h00000051;
      24: v = 30'h00000029; 25: v = 30'h00000014; 26: v = 30'h0000000A;
      27: v = 30'h00000005; 28: v = 30'h00000003; 29: v = 30'h00000001;
      default: v = '0;
    endcase
    return PH_W'($signed({1'b0, v}));
  endfunction

endpackage

// ----- hw/rtl/epr_queue.sv -----
// ----------------------------------------------------------------------------
// epr_queue
// small fifo parting the front and back of the rotation unit
// ----------------------------------------------------------------------------
module epr_queue import epr_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic         rd_valid,
  output logic [W-1:0] rd_data,
  output epr_q_stat_t  stat
);
  localparam int AW = $clog2(DEPTH);
  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  assign rd_valid  = cnt_r != '0;
  assign rd_data   = mem_r[rp_r];
  assign stat.full = cnt_r == (AW+1)'(DEPTH);
  assign stat.ovf  = wr_en && (cnt_r == (AW+1)'(DEPTH)) && !rd_en;
endmodule

// ----- hw/rtl/epr_front.sv -----
// ----------------------------------------------------------------------------
// epr_front
// pipelined cordic: one stage per step, gives sin and cos of three angles
// ----------------------------------------------------------------------------
module epr_front import epr_pkg::*; #(
  parameter int AW = ANGLE_WIDTH_DEF,
  parameter int PW = 96
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [3*AW-1:0]      ang,
  input  logic [PW-1:0]        pts,
  output logic                 out_vld,
  output logic [PW-1:0]        out_pts,
  output logic signed [CV_W-1:0] sc [6]
);
  localparam int N = CORDIC_STEPS;
  logic signed [CV_W-1:0] x_r [N+1][3];
  logic signed [CV_W-1:0] y_r [N+1][3];
  logic signed [PH_W-1:0] z_r [N+1][3];
  logic [PW-1:0]          p_r [N+1];
  logic                   v_r [N+1];
  logic signed [CV_W-1:0] x0 [3];
  logic signed [PH_W-1:0] z0 [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [31:0] ph;
      ph = {ang[a*AW +: AW], {(32-AW){1'b0}}};
      z0[a] = PH_W'(ph);
      x0[a] = CORDIC_GAIN;
      if (z0[a] > PH_W'(64'sd1 <<< 30)) begin
        x0[a] = -CORDIC_GAIN; z0[a] = z0[a] - PH_W'(64'sd1 <<< 31);
      end else if (z0[a] < -PH_W'(64'sd1 <<< 30)) begin
        x0[a] = -CORDIC_GAIN; z0[a] = z0[a] + PH_W'(64'sd1 <<< 31);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= pts;
      for (int a = 0; a < 3; a++) begin
        x_r[0][a] <= x0[a]; y_r[0][a] <= '0; z_r[0][a] <= z0[a];
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (en) begin
        p_r[i+1] <= p_r[i];
        for (int a = 0; a < 3; a++) begin
          if (!z_r[i][a][PH_W-1]) begin
            x_r[i+1][a] <= x_r[i][a] - (y_r[i][a] >>> i);
            y_r[i+1][a] <= y_r[i][a] + (x_r[i][a] >>> i);
            z_r[i+1][a] <= z_r[i][a] - atan_lut(i);
          end else begin
            x_r[i+1][a] <= x_r[i][a] + (y_r[i][a] >>> i);
            y_r[i+1][a] <= y_r[i][a] - (x_r[i][a] >>> i);
            z_r[i+1][a] <= z_r[i][a] + atan_lut(i);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
      for (int i = 0; i < N; i++) v_r[i+1] <= v_r[i];
    end
  end

  assign out_vld = v_r[N];
  assign out_pts = p_r[N];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sc[2*a]   = y_r[N][a];
      sc[2*a+1] = x_r[N][a];
    end
  end
endmodule

// ----- hw/rtl/epr_back.sv -----
// ----------------------------------------------------------------------------
// epr_back
// builds the rotation matrix and dots it with the point, then saturates
// ----------------------------------------------------------------------------
module epr_back import epr_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [3*CW+6*CV_W-1:0] in_data,
  output logic                   out_vld,
  output logic [3*CW-1:0]        out_pts
);
  localparam int PRW = 2*CV_W;
  localparam int HW  = CW - 16 + ME_W + 2;
  localparam int LW  = 16 + ME_W + 3;

  logic [5:0] v_r;
  logic signed [CV_W-1:0] sx_r, cx_r, sy_r, cy_r, sz_r, cz_r;
  logic signed [CW-1:0]   p1_r [3], p2_r [3], p3_r [3], p4_r [3];
  logic signed [CV_W-1:0] sxsy_r, cxsy_r, cy2_r, sz2_r, cz2_r, sy2_r, sx2_r, cx2_r;
  logic signed [CV_W+1:0] m_r [3][3];
  logic signed [ME_W-1:0] e_r [3][3];
  logic signed [HW+1:0]   sh_r [3];
  logic signed [LW+1:0]   sl_r [3];
  logic signed [CW-1:0]   res_r [3];

  function automatic logic signed [CV_W-1:0] m30(input logic signed [CV_W-1:0] a,
                                                  input logic signed [CV_W-1:0] b);
    logic signed [PRW-1:0] p;
    p = PRW'(a) * PRW'(b) + (PRW'(1) <<< 29);
    return CV_W'(p >>> 30);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      {p1_r[0], p1_r[1], p1_r[2]} <= in_data[6*CV_W +: 3*CW];
      {sx_r, cx_r, sy_r, cy_r, sz_r, cz_r} <= in_data[6*CV_W-1:0];
      // stage 1: pair products
      sxsy_r <= m30(sx_r, sy_r);
      cxsy_r <= m30(cx_r, sy_r);
      {sx2_r, cx2_r, sy2_r, cy2_r, sz2_r, cz2_r} <= {sx_r, cx_r, sy_r, cy_r, sz_r, cz_r};
      p2_r <= p1_r;
      // stage 2: matrix entries
      m_r[0][0] <= (CV_W+2)'(m30(cy2_r, cz2_r));
      m_r[0][1] <= (CV_W+2)'(m30(cx2_r, sz2_r)) + (CV_W+2)'(m30(sxsy_r, cz2_r));
      m_r[0][2] <= (CV_W+2)'(m30(sx2_r, sz2_r)) - (CV_W+2)'(m30(cxsy_r, cz2_r));
      m_r[1][0] <= -(CV_W+2)'(m30(cy2_r, sz2_r));
      m_r[1][1] <= (CV_W+2)'(m30(cx2_r, cz2_r)) - (CV_W+2)'(m30(sxsy_r, sz2_r));
      m_r[1][2] <= (CV_W+2)'(m30(sx2_r, cz2_r)) + (CV_W+2)'(m30(cxsy_r, sz2_r));
      m_r[2][0] <= (CV_W+2)'(sy2_r);
      m_r[2][1] <= -(CV_W+2)'(m30(sx2_r, cy2_r));
      m_r[2][2] <= (CV_W+2)'(m30(cx2_r, cy2_r));
      p3_r <= p2_r;
      // stage 3: round to q28
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          e_r[i][j] <= ME_W'((m_r[i][j] + (CV_W+2)'(2)) >>> 2);
      p4_r <= p3_r;
      // stage 4: split dot products
      for (int i = 0; i < 3; i++) begin
        logic signed [HW+1:0] h;
        logic signed [LW+1:0] l;
        h = '0; l = '0;
        for (int k = 0; k < 3; k++) begin
          h = h + (HW+2)'(p4_r[k] >>> 16) * (HW+2)'(e_r[i][k]);
          l = l + (LW+2)'($signed({1'b0, p4_r[k][15:0]})) * (LW+2)'(e_r[i][k]);
        end
        sh_r[i] <= h;
        sl_r[i] <= l;
      end
      // stage 5: combine, round and saturate
      for (int i = 0; i < 3; i++) begin
        logic signed [HW+LW+2:0] t;
        logic signed [HW+LW+2:0] hi, lo;
        t = ((HW+LW+3)'(sh_r[i]) <<< 16) + (HW+LW+3)'(sl_r[i])
            + ((HW+LW+3)'(1) <<< 27);
        t = t >>> 28;
        hi = (HW+LW+3)'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - 1;
        if (t > hi) res_r[i] <= hi[CW-1:0];
        else if (t < lo) res_r[i] <= lo[CW-1:0];
        else res_r[i] <= t[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_vld};
    end
  end

  assign out_vld = v_r[5];
  assign out_pts = {res_r[0], res_r[1], res_r[2]};
endmodule

// ----- hw/rtl/euler_point_rotation_unit.sv -----
// ----------------------------------------------------------------------------
// euler_point_rotation_unit
// rotates a q16.16 point by three euler angles; unless stalled, one transfer per cycle
// ----------------------------------------------------------------------------
// One point is accepted every cycle while the output is taken. The path runs
// through 31 cordic stages in the front, a four-entry queue that registers
// each entry, and a six-stage matrix and dot-product pipeline in the back.
// The front stalls only when the queue is full and not being read; the
// back stalls while a waiting result is held by out_stall.
`include "euler_point_rotation_unit_macros.svh"
module euler_point_rotation_unit import epr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  epr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output epr_out_t out_data
);
  localparam int COORD_WIDTH = COORD_WIDTH_DEF;
  localparam int ANGLE_WIDTH = ANGLE_WIDTH_DEF;
  localparam int PW = 3*COORD_WIDTH;
  localparam int QW = PW + 6*CV_W;
  localparam int BACK_DEPTH = 6;

  logic                   f_en, f_vld, q_vld, q_rd, b_en, b_vld;
  logic [PW-1:0]          f_pts;
  logic signed [CV_W-1:0] f_sc [6];
  logic [QW-1:0]          q_in, q_out;
  epr_q_stat_t            q_stat;
  logic [PW-1:0]          b_pts;
  logic [3:0]             cred_r, cred_nxt;
  logic                   b_take;

  // front halts only when the queue has no room for what is in flight
  assign f_en     = !q_stat.full || q_rd;
  assign in_stall = !f_en;

  epr_front #(.AW(ANGLE_WIDTH), .PW(PW)) u_front (
    .clk(clk), .rst_n(rst_n), .en(f_en), .in_vld(in_valid),
    .ang({in_data.angle_about_z, in_data.angle_about_y, in_data.angle_about_x}),
    .pts({in_data.point_x, in_data.point_y, in_data.point_z}),
    .out_vld(f_vld), .out_pts(f_pts), .sc(f_sc)
  );

  assign q_in = {f_pts, f_sc[0], f_sc[1], f_sc[2], f_sc[3], f_sc[4], f_sc[5]};

  epr_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(f_vld && f_en), .wr_data(q_in),
    .rd_en(q_rd), .rd_valid(q_vld), .rd_data(q_out), .stat(q_stat)
  );

  assign b_en  = !(out_valid && out_stall);
  assign b_take = q_vld && b_en;
  assign q_rd  = b_take;
  assign cred_nxt = cred_r;

  epr_back #(.CW(COORD_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .en(b_en), .in_vld(b_take),
    .in_data(q_out), .out_vld(b_vld), .out_pts(b_pts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= 4'(BACK_DEPTH);
    end else begin
      cred_r <= cred_nxt;
    end
  end

  assign out_valid = b_vld;
  assign out_data  = b_pts;

  `EPR_ASSERT_CLK(a_no_q_ovf, clk, rst_n, !q_stat.ovf)
  `EPR_ASSERT_CLK(a_hold_out, clk, rst_n, (out_valid && out_stall) |=> out_valid && $stable(out_data))
  `EPR_ASSERT_CLK(a_read_ok, clk, rst_n, q_rd |-> q_vld)
  `EPR_ASSERT_RST(a_cred, clk, cred_r == 4'(BACK_DEPTH) || !rst_n)
endmodule
